// File: design/rhs_pkg.sv
// rhs_pkg: shared types and constants for the rgb histogram statistics block
// no dependencies
package rhs_pkg;

    localparam int NCH = 3;

    typedef enum logic [1:0] {
        MODE_PIXEL = 2'd0,
        MODE_BIN   = 2'd1,
        MODE_STATS = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    localparam logic [1:0] REG_BIT_DEPTH = 2'd0;
    localparam logic [1:0] REG_USE_MASK  = 2'd1;

endpackage

// File: design/rhs_lane.sv
// rhs_lane: one colour channel: histogram memory with read-modify-write,
// min, max and saturating sum; depends on rhs_pkg
module rhs_lane
    import rhs_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // bump request for one sample
    input  logic                   bump,
    input  logic [SAMPLE_BITS-1:0] sample,
    // clear write
    input  logic                   clr_wr,
    input  logic [SAMPLE_BITS-1:0] clr_addr,
    input  logic                   clr_stats,
    input  logic [SAMPLE_BITS-1:0] top,
    // bin read
    input  logic                   rd,
    input  logic [SAMPLE_BITS-1:0] rd_addr,
    output logic [COUNT_BITS-1:0]  rd_data,
    output logic [SAMPLE_BITS-1:0] ch_min,
    output logic [SAMPLE_BITS-1:0] ch_max,
    output logic [35:0]            ch_sum
);
    localparam int NB = 1 << SAMPLE_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0]  mem [NB];
    logic [SAMPLE_BITS-1:0] min_reg, max_reg;
    logic [35:0]            sum_reg;
    // second stage of read-modify-write
    logic                   wb_reg;
    logic [SAMPLE_BITS-1:0] wb_addr_reg;
    logic [COUNT_BITS-1:0]  q_reg;
    logic [COUNT_BITS-1:0]  wb_val;
    logic [COUNT_BITS-1:0]  last_val_reg;
    logic                   fwd;
    logic [COUNT_BITS-1:0]  cur;
    logic [36:0]            sum_next;

    // forward a write-back to the same bin issued last cycle
    assign cur    = fwd ? last_val_reg : q_reg;
    assign wb_val = (cur == CMAX) ? cur : cur + 1'b1;
    assign rd_data = cur;

    always_ff @(posedge clk)
    begin
        if (bump || rd)
        begin
            q_reg <= mem[bump ? sample : rd_addr];
        end
        if (clr_wr)
        begin
            mem[clr_addr] <= '0;
        end
        else if (wb_reg)
        begin
            mem[wb_addr_reg] <= wb_val;
        end
        // keep the last written count while the read data is held
        if (wb_reg)
        begin
            last_val_reg <= wb_val;
        end
        wb_addr_reg  <= bump ? sample : rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_reg <= 1'b0;
            fwd    <= 1'b0;
        end
        else
        begin
            wb_reg <= bump;
            if (bump || rd)
            begin
                fwd <= wb_reg && ((bump ? sample : rd_addr) == wb_addr_reg);
            end
        end
    end

    // statistics
    assign sum_next = {1'b0, sum_reg} + {{(37-SAMPLE_BITS){1'b0}}, sample};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= SAMPLE_BITS'(8'hFF);
            max_reg <= '0;
            sum_reg <= '0;
        end
        else if (clr_stats)
        begin
            min_reg <= top;
            max_reg <= '0;
            sum_reg <= '0;
        end
        else if (bump)
        begin
            if (sample < min_reg) min_reg <= sample;
            if (sample > max_reg) max_reg <= sample;
            sum_reg <= sum_next[36] ? {36{1'b1}} : sum_next[35:0];
        end
    end

    assign ch_min = min_reg;
    assign ch_max = max_reg;
    assign ch_sum = sum_reg;
endmodule

// File: design/rhs_divider.sv
// rhs_divider: restoring divider for the channel mean, one quotient bit a cycle
// depends on rhs_pkg
module rhs_divider
    import rhs_pkg::*;
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [35:0]           sum,
    input  logic [COUNT_BITS-1:0] count,
    output logic                  done,
    output logic [19:0]           mean
);
    localparam int NB = 44;
    logic [NB-1:0]         num_reg;
    logic [NB-1:0]         quo_reg;
    logic [COUNT_BITS:0]   rem_reg;
    logic [COUNT_BITS-1:0] den_reg;
    logic [5:0]            cnt_reg;
    logic                  busy_reg;
    logic [COUNT_BITS:0]   trial;
    logic                  ge;

    assign trial = {rem_reg[COUNT_BITS-1:0], num_reg[NB-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= (count != '0);
                done     <= (count == '0);
                cnt_reg  <= 6'(NB);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {sum, 8'd0};
            den_reg <= count;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NB-2:0], 1'b0};
            rem_reg <= ge ? trial - {1'b0, den_reg} : trial;
            quo_reg <= {quo_reg[NB-2:0], ge};
        end
    end

    assign mean = (den_reg == '0) ? 20'd0 :
                  (|quo_reg[NB-1:20]) ? 20'hFFFFF : quo_reg[19:0];
endmodule

// File: design/rgb_histogram_statistics_top.sv
// rgb_histogram_statistics_top: three histogram lanes, mean divider, control
// depends on rhs_pkg, rhs_lane, rhs_divider
//
// channel  dir  handshake                   contents
// s_axis   in   s_tvalid/s_tready           mode, samples, mask, bin
// m_axis   out  m_tvalid/m_tready           counts or statistics, tlast
// apb      in   psel/penable/pwrite         bit_depth, use_mask
//
// a pixel beat is taken in the run state; back-to-back pixels use a forwarded
// read-modify-write on each lane's histogram memory
// a bin read gives its beat from the bin state, then the block returns to run
// a statistics read gives one beat per channel, each after a 44-step divide
// a clear sweeps one bin a cycle over all 2^SAMPLE_BITS bins; after reset the
// same sweep runs before the first beat is taken
// output stalls hold up bin and statistics reads only
module rgb_histogram_statistics_top
    import rhs_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode[1:0], red[13:2], green[25:14], blue[37:26], in_mask[38], bin[50:39]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // red_count[23:0], green_count[47:24], blue_count[71:48], stat_min[83:72],
    // stat_max[95:84], stat_sum[131:96], stat_mean[151:132],
    // counted_pixels[175:152]
    output logic [175:0] m_tdata,
    // channel[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int NB = 1 << SAMPLE_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    typedef enum logic [5:0] {
        ST_RUN   = 6'b000001,
        ST_CLEAR = 6'b000010,
        ST_BIN   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_OUT   = 6'b010000,
        ST_WAIT  = 6'b100000
    } state_t;

    state_t state_reg;
    logic [3:0]  depth_reg;
    logic        mask_reg;
    logic [SAMPLE_BITS-1:0] clr_reg;
    logic [COUNT_BITS-1:0]  total_reg;
    logic [1:0]  ch_reg;
    logic        bin_ok_reg;
    logic        rd_pend_reg;
    logic        out_load;

    // config port
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= 4'd8;
            mask_reg  <= 1'b0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case ({1'b0, paddr[2]})
                REG_BIT_DEPTH: depth_reg <= pwdata[3:0];
                REG_USE_MASK:  mask_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case ({1'b0, paddr[2]})
            REG_USE_MASK: prdata = {31'd0, mask_reg};
            default:      prdata = {28'd0, depth_reg};
        endcase
    end

    // depth in use and top sample value
    logic [4:0] d;
    logic [SAMPLE_BITS-1:0] top;
    always_comb
    begin
        d = {1'b0, depth_reg};
        if (d < 5'd1) d = 5'd1;
        if (d > 5'(SAMPLE_BITS)) d = 5'(SAMPLE_BITS);
        top = SAMPLE_BITS'((17'd1 << d) - 17'd1);
    end

    // input fields
    mode_t in_mode;
    logic [11:0] in_s [NCH];
    logic [SAMPLE_BITS-1:0] smp [NCH];
    logic [11:0] in_bin;
    assign in_mode = mode_t'(s_tdata[1:0]);
    assign in_s[0] = s_tdata[13:2];
    assign in_s[1] = s_tdata[25:14];
    assign in_s[2] = s_tdata[37:26];
    assign in_bin  = s_tdata[50:39];

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            smp[c] = ({4'd0, in_s[c]} > 16'(top)) ? top : SAMPLE_BITS'(in_s[c]);
        end
    end

    logic acc, bump, clr_wr, clr_stats, rd;
    logic [COUNT_BITS-1:0] rd_data [NCH];
    logic [SAMPLE_BITS-1:0] ch_min [NCH], ch_max [NCH];
    logic [35:0] ch_sum [NCH];

    assign s_tready  = (state_reg == ST_RUN);
    assign acc       = s_tvalid && s_tready;
    assign bump      = acc && in_mode == MODE_PIXEL && (!mask_reg || s_tdata[38]);
    assign rd        = acc && in_mode == MODE_BIN;
    assign clr_wr    = (state_reg == ST_CLEAR);
    assign clr_stats = acc && in_mode == MODE_CLEAR;

    for (genvar c = 0; c < NCH; c++)
    begin : g_lane
        rhs_lane #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_lane (
            .clk(clk), .rst_n(rst_n), .bump(bump), .sample(smp[c]),
            .clr_wr(clr_wr), .clr_addr(clr_reg), .clr_stats(clr_stats),
            .top(top), .rd(rd), .rd_addr(SAMPLE_BITS'(in_bin)),
            .rd_data(rd_data[c]), .ch_min(ch_min[c]), .ch_max(ch_max[c]),
            .ch_sum(ch_sum[c]));
    end

    // merging: divider on the selected channel
    logic div_start, div_done;
    logic [19:0] mean;
    rhs_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .sum(ch_sum[ch_reg]),
        .count(total_reg), .done(div_done), .mean(mean));

    assign div_start = (state_reg == ST_DIV) && !rd_pend_reg;

    // output register loads when a result is ready and the slot is free
    assign out_load = (state_reg == ST_BIN || state_reg == ST_OUT) &&
                      (!m_tvalid || m_tready);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            total_reg   <= '0;
            ch_reg      <= '0;
            bin_ok_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            m_tvalid    <= 1'b0;
            m_tdata     <= '0;
            m_tuser     <= '0;
            m_tlast     <= 1'b0;
        end
        else
        begin
            if (out_load) m_tvalid <= 1'b1;
            else if (m_tready) m_tvalid <= 1'b0;
            if (bump && total_reg != CMAX) total_reg <= total_reg + 1'b1;
            unique case (state_reg)
                ST_RUN:
                begin
                    if (acc)
                    begin
                        case (in_mode)
                            MODE_CLEAR:
                            begin
                                state_reg <= ST_CLEAR;
                                clr_reg   <= '0;
                                total_reg <= '0;
                            end
                            MODE_BIN:
                            begin
                                state_reg  <= ST_BIN;
                                bin_ok_reg <= ({4'd0, in_bin} <= 16'(top));
                            end
                            MODE_STATS:
                            begin
                                state_reg   <= ST_DIV;
                                ch_reg      <= '0;
                                rd_pend_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SAMPLE_BITS'(NB - 1)) state_reg <= ST_RUN;
                end
                ST_BIN:
                begin
                    if (out_load)
                    begin
                        m_tdata <= bin_ok_reg ?
                                   {104'd0, 24'(rd_data[2]), 24'(rd_data[1]),
                                    24'(rd_data[0])} : '0;
                        m_tuser   <= '0;
                        m_tlast   <= 1'b1;
                        state_reg <= ST_RUN;
                    end
                end
                ST_DIV:
                begin
                    rd_pend_reg <= 1'b1;
                    if (rd_pend_reg && div_done) state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        m_tdata  <= {24'(total_reg), mean, ch_sum[ch_reg],
                                     12'(ch_max[ch_reg]), 12'(ch_min[ch_reg]),
                                     72'd0};
                        m_tuser  <= ch_reg;
                        m_tlast  <= (ch_reg == 2'd2);
                        rd_pend_reg <= 1'b0;
                        if (ch_reg == 2'd2) state_reg <= ST_WAIT;
                        else
                        begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_WAIT:
                begin
                    state_reg <= ST_RUN;
                end
                default: state_reg <= ST_RUN;
            endcase
        end
    end

    // checks
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !s_tready)
        else $error("beat taken during clear sweep");
    a_tlast_stats: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && m_tuser != 2'd0 |-> m_tuser == 2'd2)
        else $error("tlast on wrong statistics channel");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
endmodule
